### rtl/rme_pkg.sv
// shared types, widths and constants for the rotation matrix to euler block
// no dependencies
package rme_pkg;

    localparam int IN_W   = 18;
    localparam int ANG_W  = 19;
    localparam int THR_W  = 17;
    localparam int GUARD  = 12;
    localparam int VW     = 34;
    localparam int ZW     = 34;
    localparam int SUM_W  = 36;
    localparam int SY_W   = 18;
    localparam int ANG_Q  = 30;
    localparam int IG_W   = 32;
    localparam int PROD_W = VW + IG_W;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    typedef logic signed [VW-1:0]   t_vec;
    typedef logic signed [ZW-1:0]   t_ang;
    typedef logic signed [IN_W-1:0] t_elem;

    localparam t_ang PI_Q30      = 34'sd3373259426;
    localparam t_ang HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [IG_W-1:0] INV_GAIN_Q30 = 32'sd652032875;

    // atan(2^-i) in Q30
    function automatic t_ang atan_q30(input int i);
        t_ang a;
        case (i)
            0:  a = 34'sd843314857;
            1:  a = 34'sd497837829;
            2:  a = 34'sd263043837;
            3:  a = 34'sd133525159;
            4:  a = 34'sd67021687;
            5:  a = 34'sd33543516;
            6:  a = 34'sd16775851;
            7:  a = 34'sd8388437;
            8:  a = 34'sd4194283;
            9:  a = 34'sd2097149;
            default: begin
                if (i < 31) begin
                    a = t_ang'(34'sd1 <<< (30 - i));
                end else begin
                    a = '0;
                end
            end
        endcase
        return a;
    endfunction

endpackage

### rtl/rme_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on rme_pkg
module rme_isqrt import rme_pkg::*; #(
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [SUM_W-1:0] i_val,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [SY_W-1:0]  o_root,
    output logic [SW-1:0]    o_side
);

    localparam int RW = SY_W + 2;

    logic             r_v    [SY_W+1];
    logic [RW-1:0]    r_rem  [SY_W+1];
    logic [SY_W-1:0]  r_q    [SY_W+1];
    logic [SUM_W-1:0] r_rest [SY_W+1];
    logic [SW-1:0]    r_sd   [SY_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_q[0]    <= '0;
        r_rest[0] <= i_val;
        r_sd[0]   <= i_side;
    end

    for (genvar s = 0; s < SY_W; s++) begin : g_bit
        logic [RW-1:0]   n_rem;
        logic [RW-1:0]   rem2;
        logic [RW-1:0]   trial;
        logic [SY_W-1:0] n_q;

        always_comb begin
            rem2  = {r_rem[s][RW-3:0], r_rest[s][SUM_W-1 -: 2]};
            trial = {r_q[s], 2'b01};
            if (rem2 >= trial) begin
                n_rem = rem2 - trial;
                n_q   = {r_q[s][SY_W-2:0], 1'b1};
            end else begin
                n_rem = rem2;
                n_q   = {r_q[s][SY_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s+1]  <= n_rem;
            r_q[s+1]    <= n_q;
            r_rest[s+1] <= {r_rest[s][SUM_W-3:0], 2'b00};
            r_sd[s+1]   <= r_sd[s];
        end
    end

    assign o_valid = r_v[SY_W];
    assign o_root  = r_q[SY_W];
    assign o_side  = r_sd[SY_W];

endmodule

### rtl/rme_cordic.sv
// pipelined vectoring cordic: first vector is driven to the x axis, the
// others follow the same rotations; depends on rme_pkg
module rme_cordic import rme_pkg::*; #(
    parameter int NV    = 1,
    parameter int STEPS = CORDIC_STEPS_DEF,
    parameter int SW    = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_vec          i_x [NV],
    input  t_vec          i_y [NV],
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output t_vec          o_x [NV],
    output t_vec          o_y [NV],
    output t_ang          o_z,
    output logic [SW-1:0] o_side
);

    logic          r_v  [STEPS+1];
    logic          r_zf [STEPS+1];
    t_vec          r_x  [STEPS+1][NV];
    t_vec          r_y  [STEPS+1][NV];
    t_ang          r_z  [STEPS+1];
    logic [SW-1:0] r_sd [STEPS+1];

    logic zero;
    logic up;
    logic turn;
    t_vec n_x [NV];
    t_vec n_y [NV];
    t_ang n_z;

    // quarter turn into the right half plane
    always_comb begin
        zero = (i_x[0] == '0) && (i_y[0] == '0);
        up   = !i_y[0][VW-1];
        turn = !zero && i_x[0][VW-1];
        for (int k = 0; k < NV; k++) begin
            if (turn && up) begin
                n_x[k] = i_y[k];
                n_y[k] = -i_x[k];
            end else if (turn) begin
                n_x[k] = -i_y[k];
                n_y[k] = i_x[k];
            end else begin
                n_x[k] = i_x[k];
                n_y[k] = i_y[k];
            end
        end
        if (turn) begin
            n_z = up ? HALF_PI_Q30 : -HALF_PI_Q30;
        end else begin
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zf[0] <= zero;
        r_x[0]  <= n_x;
        r_y[0]  <= n_y;
        r_z[0]  <= n_z;
        r_sd[0] <= i_side;
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic pos;
        t_vec st_x [NV];
        t_vec st_y [NV];
        t_ang st_z;

        always_comb begin
            pos = !r_y[s][0][VW-1];
            for (int k = 0; k < NV; k++) begin
                if (r_zf[s]) begin
                    st_x[k] = r_x[s][k];
                    st_y[k] = r_y[s][k];
                end else if (pos) begin
                    st_x[k] = r_x[s][k] + (r_y[s][k] >>> s);
                    st_y[k] = r_y[s][k] - (r_x[s][k] >>> s);
                end else begin
                    st_x[k] = r_x[s][k] - (r_y[s][k] >>> s);
                    st_y[k] = r_y[s][k] + (r_x[s][k] >>> s);
                end
            end
            if (r_zf[s]) begin
                st_z = r_z[s];
            end else if (pos) begin
                st_z = r_z[s] + atan_q30(s);
            end else begin
                st_z = r_z[s] - atan_q30(s);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_zf[s+1] <= r_zf[s];
            r_x[s+1]  <= st_x;
            r_y[s+1]  <= st_y;
            r_z[s+1]  <= st_z;
            r_sd[s+1] <= r_sd[s];
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_x     = r_x[STEPS];
    assign o_y     = r_y[STEPS];
    assign o_z     = r_z[STEPS];
    assign o_side  = r_sd[STEPS];

endmodule

### rtl/rotation_matrix_to_euler_top.sv
// zyx euler angles from a rotation matrix; squares, sum, 19 root stages, yaw
// cordic, gain multiply, pitch and roll cordics in parallel, output register.
// one request per cycle, busy stays low. synchronous active-low reset empties
// the pipeline and sets the threshold to 1. results leave on a one-cycle strobe
// with no back pressure
// depends on rme_pkg, rme_isqrt, rme_cordic
module rotation_matrix_to_euler_top import rme_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cfg_we,
    input  logic [THR_W-1:0]        i_cfg_wdata,
    input  logic signed [IN_W-1:0]  i_m00,
    input  logic signed [IN_W-1:0]  i_m01,
    input  logic signed [IN_W-1:0]  i_m02,
    input  logic signed [IN_W-1:0]  i_m10,
    input  logic signed [IN_W-1:0]  i_m11,
    input  logic signed [IN_W-1:0]  i_m12,
    input  logic signed [IN_W-1:0]  i_m20,
    output logic                    o_done,
    output logic signed [ANG_W-1:0] o_yaw_angle,
    output logic signed [ANG_W-1:0] o_pitch_angle,
    output logic signed [ANG_W-1:0] o_roll_angle,
    output logic                    o_gimbal_lock
);

    localparam int   SH    = ANG_Q - FRAC_BITS;
    localparam t_ang RHALF = t_ang'((t_ang'(1) <<< SH) >>> 1);
    localparam t_ang PI_R  = (PI_Q30 + RHALF) >>> SH;
    localparam int   M_W   = 7 * IN_W;
    localparam int   S1_W  = 1 + SY_W + 3 * IN_W;
    localparam int   LAT   = 2 + (SY_W + 1) + (CORDIC_STEPS + 1) + 1
                             + (CORDIC_STEPS + 1) + 1;

    function automatic t_vec guard_up(input t_elem m);
        return t_vec'(m) <<< GUARD;
    endfunction

    function automatic logic signed [ANG_W-1:0] to_angle(input t_ang z);
        t_ang r;
        r = (z + RHALF) >>> SH;
        if (r > PI_R) begin
            r = r - (PI_R <<< 1);
        end else if (r <= -PI_R) begin
            r = r + (PI_R <<< 1);
        end
        return r[ANG_W-1:0];
    endfunction

    logic w_acc;
    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    logic [THR_W-1:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // squares and sum
    logic                     r0_v;
    logic signed [2*IN_W-1:0] r0_p00;
    logic signed [2*IN_W-1:0] r0_p10;
    logic [M_W-1:0]           r0_m;
    logic                     r1_v;
    logic [SUM_W-1:0]         r1_sum;
    logic [M_W-1:0]           r1_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
        end else begin
            r0_v <= w_acc;
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_p00 <= i_m00 * i_m00;
        r0_p10 <= i_m10 * i_m10;
        r0_m   <= {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20};
        r1_sum <= SUM_W'(unsigned'(r0_p00)) + SUM_W'(unsigned'(r0_p10));
        r1_m   <= r0_m;
    end

    logic             sq_v;
    logic [SY_W-1:0]  sq_root;
    logic [M_W-1:0]   sq_m;

    rme_isqrt #(.SW(M_W)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_v),
        .i_val   (r1_sum),
        .i_side  (r1_m),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_m)
    );

    t_elem w_m00, w_m01, w_m02, w_m10, w_m11, w_m12, w_m20;
    logic  w_sing;
    t_vec  c1_ix [3];
    t_vec  c1_iy [3];

    always_comb begin
        {w_m00, w_m01, w_m02, w_m10, w_m11, w_m12, w_m20} = sq_m;
        w_sing   = sq_root < SY_W'(r_thr);
        c1_ix[0] = guard_up(w_m00);
        c1_iy[0] = guard_up(w_m10);
        c1_ix[1] = guard_up(w_m01);
        c1_iy[1] = guard_up(w_m11);
        c1_ix[2] = guard_up(w_m02);
        c1_iy[2] = guard_up(w_m12);
    end

    logic            c1_v;
    t_vec            c1_x [3];
    t_vec            c1_y [3];
    t_ang            c1_z;
    logic [S1_W-1:0] c1_side;

    rme_cordic #(.NV(3), .STEPS(CORDIC_STEPS), .SW(S1_W)) u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_v),
        .i_x     (c1_ix),
        .i_y     (c1_iy),
        .i_side  ({w_sing, sq_root, w_m20, w_m11, w_m12}),
        .o_valid (c1_v),
        .o_x     (c1_x),
        .o_y     (c1_y),
        .o_z     (c1_z),
        .o_side  (c1_side)
    );

    // gain correction of the rotated x term
    logic                     r2_v;
    logic signed [PROD_W-1:0] r2_prod;
    t_vec                     r2_v3;
    t_vec                     r2_v5;
    t_ang                     r2_yaw;
    logic [S1_W-1:0]          r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_prod <= c1_x[0] * INV_GAIN_Q30;
        r2_v3   <= c1_y[1];
        r2_v5   <= c1_y[2];
        r2_yaw  <= c1_z;
        r2_side <= c1_side;
    end

    logic            w2_sing;
    logic [SY_W-1:0] w2_sy;
    t_elem           w2_m20, w2_m11, w2_m12;
    t_vec            w2_den;
    t_vec            cp_ix [1];
    t_vec            cp_iy [1];
    t_vec            cr_ix [1];
    t_vec            cr_iy [1];

    always_comb begin
        {w2_sing, w2_sy, w2_m20, w2_m11, w2_m12} = r2_side;
        w2_den   = t_vec'(r2_prod >>> ANG_Q);
        cp_iy[0] = -guard_up(w2_m20);
        if (w2_sing) begin
            cp_ix[0] = t_vec'(w2_sy) <<< GUARD;
            cr_ix[0] = guard_up(w2_m11);
            cr_iy[0] = -guard_up(w2_m12);
        end else begin
            cp_ix[0] = w2_den;
            cr_ix[0] = r2_v3;
            cr_iy[0] = -r2_v5;
        end
    end

    logic cp_v, cr_v, cr_sing;
    t_vec cp_x [1];
    t_vec cp_y [1];
    t_vec cr_x [1];
    t_vec cr_y [1];
    t_ang cp_z, cr_z, cp_yaw;

    rme_cordic #(.NV(1), .STEPS(CORDIC_STEPS), .SW(ZW)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_v),
        .i_x     (cp_ix),
        .i_y     (cp_iy),
        .i_side  (r2_yaw),
        .o_valid (cp_v),
        .o_x     (cp_x),
        .o_y     (cp_y),
        .o_z     (cp_z),
        .o_side  (cp_yaw)
    );

    rme_cordic #(.NV(1), .STEPS(CORDIC_STEPS), .SW(1)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_v),
        .i_x     (cr_ix),
        .i_y     (cr_iy),
        .i_side  (w2_sing),
        .o_valid (cr_v),
        .o_x     (cr_x),
        .o_y     (cr_y),
        .o_z     (cr_z),
        .o_side  (cr_sing)
    );

    logic r_done;
    logic signed [ANG_W-1:0] r_yaw, r_pitch, r_roll;
    logic r_gl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= cp_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_yaw   <= cr_sing ? '0 : to_angle(cp_yaw);
        r_pitch <= to_angle(cp_z);
        r_roll  <= to_angle(cr_z);
        r_gl    <= cr_sing;
    end

    assign o_done        = r_done;
    assign o_yaw_angle   = r_yaw;
    assign o_pitch_angle = r_pitch;
    assign o_roll_angle  = r_roll;
    assign o_gimbal_lock = r_gl;

`ifndef SYNTHESIS
    a_done_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_acc, LAT))
        else $error("result strobe without a matching request");

    a_units_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cp_v == cr_v)
        else $error("pitch and roll pipelines out of step");

    a_lock_zero_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_gimbal_lock |-> o_yaw_angle == '0)
        else $error("gimbal lock with nonzero yaw");

    a_zero_thr_no_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && r_thr == '0 && $stable(r_thr) |-> !o_gimbal_lock)
        else $error("singular branch taken with zero threshold");
`endif

endmodule
